/* rtl/stack_machine_alu_unit_assert.svh */
// Assertion macros shared by the stack machine RTL.
`ifndef STACK_MACHINE_ALU_UNIT_ASSERT_SVH
`define STACK_MACHINE_ALU_UNIT_ASSERT_SVH
// Checks that an antecedent implies a consequent at the same edge.
`define SMA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Checks that an antecedent implies a consequent at the next edge.
`define SMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/sma_pkg.sv */
//------------------------------------------------------------------------------
// Stack machine package
// Shared types, beat formats, codes and sizes for the stack machine ALU.
//------------------------------------------------------------------------------
`default_nettype none

package sma_pkg;

    localparam int StackDepth = 32;
    localparam int AddrW = $clog2(StackDepth);
    localparam int CountW = $clog2(StackDepth + 1);
    localparam logic [6:0] NewlineCode = 7'd10;
    localparam logic signed [31:0] CharMax = 32'sd127;

    typedef enum logic [2:0] {
        CMD_PUSH  = 3'd0,
        CMD_MUL   = 3'd1,
        CMD_MOD   = 3'd2,
        CMD_PCHAR = 3'd3,
        CMD_PSTR  = 3'd4,
        CMD_ROTL  = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_DIVZERO  = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_RANGE    = 3'd4,
        ST_OVERFLOW = 3'd5
    } status_t;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] push_value;
    } in_beat_t;

    typedef struct packed {
        logic       is_char;
        logic [6:0] char_code;
        logic [2:0] status;
        logic       last;
    } out_beat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_TOP,
        S_WAIT_TOP,
        S_RD_NEXT,
        S_WAIT_NEXT,
        S_ARITH,
        S_WRITE,
        S_PSTR_RD,
        S_PSTR_CHK,
        S_ROT_RD,
        S_ROT_MOVE,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic        start;
        logic        is_mod;
        logic [31:0] a;
        logic [31:0] b;
    } arith_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } arith_rsp_t;

endpackage

`default_nettype wire

/* rtl/sma_ram.sv */
//------------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
//------------------------------------------------------------------------------
`default_nettype none

module sma_ram #(
    parameter int Width = 32,
    parameter int Depth = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(Depth)-1:0] wr_addr,
    input  wire logic [Width-1:0]         wr_data,
    input  wire logic [$clog2(Depth)-1:0] rd_addr,
    output logic      [Width-1:0]         rd_data
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/sma_arith.sv */
//------------------------------------------------------------------------------
// Stack machine arithmetic unit
// Shift and add multiplier and restoring divider; the divider uses a 33-bit trial subtract.
//------------------------------------------------------------------------------
`default_nettype none

module sma_arith
    import sma_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire arith_req_t req,
    output arith_rsp_t      rsp
);

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        mod_reg, mod_next;
    logic        neg_reg, neg_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] b_reg, b_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [31:0] shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        mod_reg <= mod_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        q_reg   <= q_next;
        b_reg   <= b_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mod_next  = mod_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        q_next    = q_reg;
        b_next    = b_reg;
        shifted   = {acc_reg[30:0], q_reg[31]};
        trial     = {1'b0, shifted} - {1'b0, b_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            mod_next  = req.is_mod;
            acc_next  = 32'd0;
            if (req.is_mod)
            begin
                neg_next = req.a[31];
                q_next   = req.a[31] ? (32'd0 - req.a) : req.a;
                b_next   = req.b[31] ? (32'd0 - req.b) : req.b;
            end
            else
            begin
                neg_next = 1'b0;
                q_next   = req.a;
                b_next   = req.b;
            end
        end
        else if (busy_reg)
        begin
            if (mod_reg)
            begin
                q_next = {q_reg[30:0], 1'b0};
                if (!trial[32])
                begin
                    acc_next = trial[31:0];
                end
                else
                begin
                    acc_next = shifted;
                end
            end
            else
            begin
                if (b_reg[cnt_reg[4:0]])
                begin
                    acc_next = acc_reg + q_reg;
                end
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = (mod_reg && neg_reg) ? (32'd0 - acc_reg) : acc_reg;

endmodule

`default_nettype wire

/* rtl/stack_machine_alu_unit.sv */
//------------------------------------------------------------------------------
// Stack machine ALU unit
// Bounded stack of signed words driven by push, mul, mod, pchar, pstr, rotl.
//------------------------------------------------------------------------------
// One command is taken at a time and the input is stalled until its last
// result beat is taken. Mul and mod run on the 32-step shared multiply/divide
// unit, and rotl moves the stack one word at a time, set by the single read
// port of the stack RAM.
// An output register holds each result beat until it is taken.
`default_nettype none

module stack_machine_alu_unit
    import sma_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_beat_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_beat_t      out_data
);

`include "stack_machine_alu_unit_assert.svh"

    state_t              state_reg, state_next;
    logic [CountW-1:0]   count_reg, count_next;
    logic [2:0]          cmd_reg, cmd_next;
    logic [31:0]         top_reg, top_next;
    logic [CountW-1:0]   idx_reg, idx_next;
    logic                ov_reg, ov_next;
    out_beat_t           ob_reg, ob_next;
    state_t              after_reg, after_next;

    logic                wr_en;
    logic [AddrW-1:0]    wr_addr, rd_addr;
    logic [31:0]         wr_data, rd_data;
    arith_req_t          areq;
    arith_rsp_t          arsp;
    logic                in_acc;
    logic signed [31:0]  rd_s;

    sma_ram #(.Width(32), .Depth(StackDepth)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sma_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (areq),
        .rsp   (arsp)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = ov_reg;
    assign out_data  = ob_reg;
    assign rd_s      = rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        top_reg   <= top_next;
        idx_reg   <= idx_next;
        ob_reg    <= ob_next;
        after_reg <= after_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cmd_next   = cmd_reg;
        top_next   = top_reg;
        idx_next   = idx_reg;
        ov_next    = ov_reg && out_stall;
        ob_next    = ob_reg;
        after_next = after_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg[AddrW-1:0];
        wr_data    = top_reg;
        rd_addr    = idx_reg[AddrW-1:0];
        areq       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    cmd_next   = in_data.command;
                    ob_next    = '{is_char: 1'b0, char_code: 7'd0, status: ST_OK, last: 1'b1};
                    after_next = S_IDLE;
                    state_next = S_EMIT;
                    case (in_data.command)
                        CMD_PUSH:
                        begin
                            if (count_reg >= CountW'(StackDepth))
                            begin
                                ob_next.status = ST_OVERFLOW;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[AddrW-1:0];
                                wr_data    = in_data.push_value;
                                count_next = count_reg + CountW'(1);
                            end
                        end
                        CMD_MUL, CMD_MOD:
                        begin
                            if (count_reg < CountW'(2))
                            begin
                                ob_next.status = ST_SHORT;
                            end
                            else
                            begin
                                idx_next   = count_reg - CountW'(1);
                                state_next = S_RD_TOP;
                            end
                        end
                        CMD_PCHAR:
                        begin
                            if (count_reg == '0)
                            begin
                                ob_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = count_reg - CountW'(1);
                                state_next = S_RD_TOP;
                            end
                        end
                        CMD_PSTR:
                        begin
                            idx_next   = count_reg;
                            state_next = S_PSTR_RD;
                        end
                        CMD_ROTL:
                        begin
                            if (count_reg != '0)
                            begin
                                idx_next   = count_reg - CountW'(1);
                                state_next = S_RD_TOP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD_TOP:
            begin
                state_next = S_WAIT_TOP;
            end
            S_WAIT_TOP:
            begin
                top_next = rd_data;
                if (cmd_reg == CMD_PCHAR)
                begin
                    if (rd_s < 0 || rd_s > CharMax)
                    begin
                        ob_next.status = ST_RANGE;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        ob_next    = '{is_char: 1'b1, char_code: rd_data[6:0],
                                       status: ST_OK, last: 1'b0};
                        after_next = S_EMIT;
                        state_next = S_EMIT;
                    end
                end
                else if (cmd_reg == CMD_ROTL)
                begin
                    state_next = S_ROT_RD;
                end
                else
                begin
                    idx_next   = idx_reg - CountW'(1);
                    state_next = S_RD_NEXT;
                end
            end
            S_RD_NEXT:
            begin
                state_next = S_WAIT_NEXT;
            end
            S_WAIT_NEXT:
            begin
                if (cmd_reg == CMD_MOD && top_reg == 32'd0)
                begin
                    ob_next.status = ST_DIVZERO;
                    state_next     = S_EMIT;
                end
                else
                begin
                    areq.start  = 1'b1;
                    areq.is_mod = (cmd_reg == CMD_MOD);
                    areq.a      = rd_data;
                    areq.b      = top_reg;
                    state_next  = S_ARITH;
                end
            end
            S_ARITH:
            begin
                if (arsp.done)
                begin
                    wr_en      = 1'b1;
                    wr_data    = arsp.result;
                    count_next = count_reg - CountW'(1);
                    state_next = S_EMIT;
                end
            end
            S_PSTR_RD:
            begin
                if (idx_reg == '0)
                begin
                    ob_next    = '{is_char: 1'b1, char_code: NewlineCode,
                                   status: ST_OK, last: 1'b1};
                    after_next = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_addr    = AddrW'(idx_reg - CountW'(1));
                    state_next = S_PSTR_CHK;
                end
            end
            S_PSTR_CHK:
            begin
                if (rd_s <= 0 || rd_s > CharMax)
                begin
                    ob_next    = '{is_char: 1'b1, char_code: NewlineCode,
                                   status: ST_OK, last: 1'b1};
                    after_next = S_IDLE;
                end
                else
                begin
                    ob_next    = '{is_char: 1'b1, char_code: rd_data[6:0],
                                   status: ST_OK, last: 1'b0};
                    idx_next   = idx_reg - CountW'(1);
                    after_next = S_PSTR_RD;
                end
                state_next = S_EMIT;
            end
            S_ROT_RD:
            begin
                if (idx_reg == '0)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    wr_data    = top_reg;
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_addr    = AddrW'(idx_reg - CountW'(1));
                    state_next = S_ROT_MOVE;
                end
            end
            S_ROT_MOVE:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg[AddrW-1:0];
                wr_data    = rd_data;
                idx_next   = idx_reg - CountW'(1);
                state_next = S_ROT_RD;
            end
            S_EMIT:
            begin
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    if (after_reg == S_EMIT)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = (after_reg == S_PSTR_RD) ? S_PSTR_RD : S_IDLE;
                    end
                end
                if (after_reg == S_EMIT && !ov_reg)
                begin
                    after_next = S_IDLE;
                    state_next = S_EMIT;
                end
                if (after_reg == S_IDLE && !ov_reg && ob_reg.is_char && !ob_reg.last)
                begin
                    state_next = S_EMIT;
                end
                if (ov_reg && !out_stall && ob_reg.is_char && !ob_reg.last
                    && cmd_reg == CMD_PCHAR)
                begin
                    ob_next    = '{is_char: 1'b1, char_code: NewlineCode,
                                   status: ST_OK, last: 1'b1};
                    after_next = S_IDLE;
                    state_next = S_EMIT;
                end
                else if (ov_reg && out_stall)
                begin
                    state_next = S_EMIT;
                end
                else if (ov_reg && !out_stall)
                begin
                    state_next = (after_reg == S_PSTR_RD) ? S_PSTR_RD : S_IDLE;
                    if (after_reg == S_PSTR_RD)
                    begin
                        ov_next = 1'b0;
                    end
                end
                else if (!ov_reg)
                begin
                    state_next = S_EMIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `SMA_ASSERT_IMPLY(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, in_stall,
        "input accepted while busy")
    `SMA_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= CountW'(StackDepth),
        "stack count beyond depth")
    `SMA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid,
        "result beat dropped while stalled")
    `SMA_ASSERT_IMPLY(a_idle_no_out, clk, rst_n, state_reg == S_IDLE, !out_valid,
        "result beat pending while idle")

endmodule

`default_nettype wire
